// File: rtl/u8d_pkg.sv
// Shared types and codes for the UTF-8 byte stream decoder.
`timescale 1ns / 1ps

package u8d_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_SHIFT = 1'b1;

	localparam logic [1:0] RES_NONE = 2'd0;
	localparam logic [1:0] RES_CHAR = 2'd1;
	localparam logic [1:0] RES_PART = 2'd2;

	typedef struct packed {
		logic       op;
		logic [7:0] val;
		logic [1:0] res;
	} u8d_entry_t;

endpackage

// File: rtl/utf8_byte_stream_decoder.sv
// Top level of the UTF-8 byte stream decoder.
// Usage:
//   Slave channel s_*: one raw byte per beat in s_tdata, s_tlast marks the
//   last byte of a buffer. Master channel m_*: one beat per decoded
//   character (m_tuser = 0, code point in m_tdata) or per buffer that ends
//   inside an unfinished sequence (m_tuser = 1, m_tdata = 0). Bytes in the
//   middle of a sequence give no beat.
//   Throughput: one byte per cycle sustained while m_tready is high. The
//   classifier keeps the sequence count, the accumulator does one
//   shift-and-or per byte. Path: the last byte of a result is written into
//   the command queue at the edge that accepts it; the result moves into
//   the output register when the accumulator pops that command.
//   Stall: while a result waits with m_tready low the accumulator stops;
//   the command queue (QUEUE_DEPTH beats) absorbs input, then s_tready drops.
//   Reset: arst_n clears the pending sequence, the accumulator, the queue
//   and the output valid; no clearing pass is needed.
`timescale 1ns / 1ps

module utf8_byte_stream_decoder #(
	parameter int QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_buffer
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] code_point
	output logic        m_tuser    // [0] status
);
	import u8d_pkg::*;

	logic       accept;
	u8d_entry_t front_entry;
	logic       q_valid;
	logic       q_pop;
	u8d_entry_t q_head;

	assign accept = s_tvalid && s_tready;

	u8d_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (s_tdata),
		.end_of_buffer (s_tlast),
		.entry         (front_entry)
	);

	u8d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_entry (front_entry),
		.ready      (s_tready),
		.pop        (q_pop),
		.valid      (q_valid),
		.head       (q_head)
	);

	u8d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_head),
		.cmd_pop   (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// File: rtl/u8d_front.sv
// Byte classifier: tracks sequence position and builds back-end commands.
`timescale 1ns / 1ps

module u8d_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	input  logic                end_of_buffer,
	output u8d_pkg::u8d_entry_t entry
);
	import u8d_pkg::*;

	logic [2:0] rem_q;
	logic [2:0] ones;
	logic [2:0] rem_nxt;
	logic [3:0] shamt;
	logic [7:0] keep;

	always_comb begin
		priority casez (data_byte)
			8'b0???????: ones = 3'd0;
			8'b10??????: ones = 3'd1;
			8'b110?????: ones = 3'd2;
			8'b1110????: ones = 3'd3;
			8'b11110???: ones = 3'd4;
			8'b111110??: ones = 3'd5;
			8'b1111110?: ones = 3'd6;
			default:     ones = 3'd7;
		endcase
	end

	assign shamt = {1'b0, ones} + 4'd1;
	assign keep  = 8'hFF >> shamt;

	always_comb begin
		if (rem_q == 3'd0) begin
			entry.op = OP_LOAD;
			entry.val = data_byte & keep;
			rem_nxt = (ones == 3'd0) ? 3'd0 : ones - 3'd1;
		end else begin
			entry.op = OP_SHIFT;
			entry.val = {2'b00, data_byte[5:0]};
			rem_nxt = rem_q - 3'd1;
		end
		if (rem_nxt == 3'd0)
			entry.res = RES_CHAR;
		else if (end_of_buffer)
			entry.res = RES_PART;
		else
			entry.res = RES_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
		end else if (accept) begin
			rem_q <= rem_nxt;
		end
	end

endmodule

// File: rtl/u8d_queue.sv
// Small command queue between classifier and accumulator.
`timescale 1ns / 1ps

module u8d_queue #(
	parameter int DEPTH = u8d_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  u8d_pkg::u8d_entry_t push_entry,
	output logic                ready,
	input  logic                pop,
	output logic                valid,
	output u8d_pkg::u8d_entry_t head
);
	import u8d_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	u8d_entry_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign ready = (count_q != FULL);
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL) else $error("queue count over depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != FULL || pop)) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0) else $error("pop from empty queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not advance");

endmodule

// File: rtl/u8d_back.sv
// Accumulator and output register: executes queued commands.
`timescale 1ns / 1ps

module u8d_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  u8d_pkg::u8d_entry_t cmd,
	output logic                cmd_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,
	output logic                m_tuser
);
	import u8d_pkg::*;

	logic [31:0] acc_q;
	logic [31:0] acc_nxt;
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        out_status_q;

	assign cmd_pop = cmd_valid && (!out_valid_q || m_tready);
	assign acc_nxt = (cmd.op == OP_LOAD) ? {24'd0, cmd.val} : {acc_q[25:0], cmd.val[5:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_pop)
				acc_q <= acc_nxt;
			if (cmd_pop && cmd.res != RES_NONE)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.res == RES_CHAR) begin
			out_data_q   <= acc_nxt;
			out_status_q <= 1'b0;
		end else if (cmd_pop && cmd.res == RES_PART) begin
			out_data_q   <= 32'd0;
			out_status_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

	a_partial_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tdata == 32'd0) else $error("partial beat with data");
	a_stall_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !cmd_pop) else $error("pop while output stalled");
	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_pop |=> $stable(acc_q)) else $error("accumulator moved without command");

endmodule
